// File: sv/sidta_pkg.sv
// Package: widths, character codes, queue entry and state types for the decimal text converter.
`default_nettype none
package sidta_pkg;

  localparam int VALUE_WIDTH = 32;

  // Number of decimal digits in the largest magnitude, 2**(width-1).
  function automatic int digits_for_width(input int width);
    logic [63:0] x;
    int          n;
    x = 64'd1 << (width - 1);
    n = 0;
    while (x != 64'd0) begin
      x = x / 10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int DIGIT_COUNT = digits_for_width(VALUE_WIDTH);
  localparam int BCD_W       = 4 * DIGIT_COUNT;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int IDX_W       = $clog2(DIGIT_COUNT);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } num_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_LEAD,
    S_SIGN,
    S_DIG
  } back_state_t;

endpackage
`default_nettype wire

// File: sv/sidta_if.sv
// Interfaces: integer input channel and character output channel.
`default_nettype none
interface sidta_value_if import sidta_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidta_char_if import sidta_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

// File: sv/sidta_front.sv
// Front end: accepts integers, splits off the sign and forms the unsigned magnitude.
`default_nettype none
module sidta_front import sidta_pkg::*; (
  sidta_value_if.sink num,
  input  q_status_t   q_status,
  output logic        push,
  output num_entry_t  push_data
);

  logic [VALUE_WIDTH-1:0] raw;

  assign raw       = num.value;
  assign num.ready = !q_status.full;
  assign push      = num.valid && !q_status.full;

  // Negate as unsigned so the most negative value keeps its full magnitude.
  always_comb begin
    push_data.neg = raw[VALUE_WIDTH-1];
    push_data.mag = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
  end

endmodule
`default_nettype wire

// File: sv/sidta_queue.sv
// Short queue of classified numbers between the front end and the converter.
`default_nettype none
module sidta_queue import sidta_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  num_entry_t push_data,
  input  logic       pop,
  output num_entry_t pop_data,
  output q_status_t  q_status
);

  num_entry_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign q_status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_data       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: sv/sidta_back.sv
// Back end: shift-and-add-3 binary to BCD conversion and serial character output.
`default_nettype none
module sidta_back import sidta_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  num_entry_t pop_data,
  input  q_status_t  q_status,
  output logic       pop,
  sidta_char_if.source chars
);

  back_state_t            state;
  back_state_t            state_next;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       cnt;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       lead;
  logic [3:0]             digit;
  logic                   out_valid;
  logic [CHAR_W-1:0]      out_char;
  logic                   out_last;
  logic                   slot_free;
  logic                   load;
  logic                   conv;
  logic                   lead_load;
  logic                   idx_dec;
  logic                   emit;
  logic [CHAR_W-1:0]      emit_char;
  logic                   emit_last;

  assign chars.valid     = out_valid;
  assign chars.char_code = out_char;
  assign chars.last_char = out_last;
  assign slot_free       = !out_valid || chars.ready;
  assign digit           = bcd[idx*4 +: 4];

  // Add 3 to every BCD digit of 5 or more before the next shift.
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  // Highest nonzero digit; zero keeps index 0 so a lone '0' goes out.
  always_comb begin
    lead = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        lead = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (!q_status.empty) state_next = S_CONV;
      S_CONV: if (cnt == CNT_W'(VALUE_WIDTH - 1)) state_next = S_LEAD;
      S_LEAD: state_next = neg ? S_SIGN : S_DIG;
      S_SIGN: if (slot_free) state_next = S_DIG;
      S_DIG:  if (slot_free && (idx == '0)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    load      = 1'b0;
    conv      = 1'b0;
    lead_load = 1'b0;
    idx_dec   = 1'b0;
    emit      = 1'b0;
    emit_char = CHAR_ZERO;
    emit_last = 1'b0;
    case (state)
      S_IDLE: begin
        pop  = !q_status.empty;
        load = !q_status.empty;
      end
      S_CONV: begin
        conv = 1'b1;
      end
      S_LEAD: begin
        lead_load = 1'b1;
      end
      S_SIGN: begin
        emit      = slot_free;
        emit_char = CHAR_MINUS;
      end
      S_DIG: begin
        emit      = slot_free;
        emit_char = CHAR_ZERO + {{(CHAR_W-4){1'b0}}, digit};
        emit_last = (idx == '0);
        idx_dec   = slot_free && (idx != '0);
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag <= pop_data.mag;
      neg <= pop_data.neg;
      bcd <= '0;
      cnt <= '0;
    end
    if (conv) begin
      bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_WIDTH-1]};
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end
    if (lead_load) begin
      idx <= lead;
    end
    if (idx_dec) begin
      idx <= idx - IDX_W'(1);
    end
    if (emit) begin
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

endmodule
`default_nettype wire

// File: sv/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text converter.
//
// Input channel num (valid/ready) carries one signed VALUE_WIDTH-bit integer per
// transfer. Output channel chars (valid/ready) gives its decimal text, most
// significant character first: a '-' for negative values, then the digits with
// no leading zeros (zero gives a single '0'). last_char marks the final
// character of each number; there is no terminator.
// The front end takes the sign and magnitude and places them in a two-entry
// queue, so the input keeps accepting while the converter is busy.
// The converter pops one number, runs VALUE_WIDTH shift-and-add-3 steps (one
// input bit per cycle), locates the leading digit in a separate state, then
// emits one character per cycle into the output register while the receiver
// accepts, and pops the next number only after its last character. For a
// negative value the first character is the '-'. A stalled receiver holds the
// output register and freezes character emission; the queue then fills and
// num.ready drops.
// Reset (rst, synchronous) empties the queue and the output register and
// returns the converter to idle.
`default_nettype none
module signed_int_to_decimal_ascii import sidta_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sidta_value_if.sink  num,
  sidta_char_if.source chars
);

  q_status_t  q_status;
  logic       push;
  logic       pop;
  num_entry_t push_data;
  num_entry_t pop_data;

  sidta_front u_front (
    .num       (num),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  sidta_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  sidta_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .q_status (q_status),
    .pop      (pop),
    .chars    (chars)
  );

endmodule
`default_nettype wire

// File: sv/sidta_checker.sv
// Checker: port-level assertions on the converter, bound to the top level.
`default_nettype none
module sidta_checker import sidta_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] char_code,
  input logic              last_char
);

  // Hold a stalled character.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_char))
    else $error("stalled character changed or dropped");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == CHAR_MINUS) ||
                  ((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE)))
    else $error("character code outside minus and digits");

  // A minus sign always has digits after it.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (char_code == CHAR_MINUS) |-> !last_char)
    else $error("minus sign flagged as last character");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii sidta_checker u_sidta_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (chars.valid),
  .out_ready (chars.ready),
  .char_code (chars.char_code),
  .last_char (chars.last_char)
);
`default_nettype wire
